@@ rtl/q2r_pkg.sv @@
`default_nettype none
package q2r_pkg;
    localparam int IN_W       = 16;
    localparam int OUT_W      = 16;
    localparam int PROD_W     = 2 * IN_W;
    localparam int NORM_W     = PROD_W + 1;
    localparam int SUM_W      = PROD_W + 3;
    localparam int QUOT_W     = 16;
    localparam int ENTRIES    = 9;
    localparam int DIV_BITS   = 3;
    localparam int DIV_STAGES = (QUOT_W - 1) / DIV_BITS;
    localparam logic signed [OUT_W-1:0] ONE_Q14 = 16'sd16384;

    typedef logic [NORM_W-1:0] norm_t;
    typedef logic [QUOT_W-1:0] quot_t;
    typedef logic signed [OUT_W-1:0] entry_t;
endpackage
`default_nettype wire

@@ rtl/q2r_quat_if.sv @@
`default_nettype none
interface q2r_quat_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;

    modport source (output valid, quat_x, quat_y, quat_z, quat_w, input ready);
    modport sink   (input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface
`default_nettype wire

@@ rtl/q2r_mat_if.sv @@
`default_nettype none
interface q2r_mat_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
    logic               degenerate;

    modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                    degenerate, input ready);
    modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                    degenerate, output ready);
endinterface
`default_nettype wire

@@ rtl/q2r_div_step.sv @@
`default_nettype none
module q2r_div_step (
    input  wire                 clk,
    input  wire                 en,
    input  wire q2r_pkg::norm_t n,
    input  wire q2r_pkg::norm_t rem_in,
    input  wire q2r_pkg::quot_t quot_in,
    output q2r_pkg::norm_t      rem_reg,
    output q2r_pkg::quot_t      quot_reg
);
    import q2r_pkg::*;

    norm_t              rem_next;
    quot_t              quot_next;
    logic [NORM_W:0]    trial;

    // restoring division, several quotient bits per stage
    always_comb
    begin
        rem_next  = rem_in;
        quot_next = quot_in;
        trial     = '0;
        for (int k = 0; k < DIV_BITS; k++)
        begin
            trial = {rem_next, 1'b0};
            if (trial >= {1'b0, n})
            begin
                trial     = trial - {1'b0, n};
                quot_next = {quot_next[QUOT_W-2:0], 1'b1};
            end
            else
            begin
                quot_next = {quot_next[QUOT_W-2:0], 1'b0};
            end
            rem_next = trial[NORM_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            quot_reg <= quot_next;
        end
    end
endmodule
`default_nettype wire

@@ rtl/quaternion_to_rotation_matrix.sv @@
`default_nettype none
// Quaternion to 3x3 rotation matrix. Takes one quaternion (x, y, z, w) in
// signed Q2.14 per transaction and returns the nine rotation entries in signed
// Q1.14, each equal to its pairwise-product expression divided by the squared
// norm (no square root), rounded to nearest with ties away from zero and held
// within +/-1.0. A zero quaternion returns the identity with degenerate set.
// Throughput is one transaction per cycle while the output is not stalled.
// Stages: product multipliers, norm and numerator sums, five restoring-divider
// stages of three quotient bits each (nine dividers side by side), then
// rounding into the output register. The whole pipeline advances together; it
// holds when the output register is full and not taken, and input ready
// follows that condition.
module quaternion_to_rotation_matrix (
    input  wire        clk,
    input  wire        rst_n,
    q2r_quat_if.sink   quat,
    q2r_mat_if.source  matrix
);
    import q2r_pkg::*;

    localparam int LAT = DIV_STAGES + 3;

    logic [LAT-1:0] valid_reg;
    logic           en;

    // advance everything when the last stage is empty or being taken
    assign en         = !valid_reg[LAT-1] || matrix.ready;
    assign quat.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[LAT-2:0], quat.valid};
        end
    end

    // stage 1: pairwise products
    logic signed [PROD_W-1:0] xx_reg, yy_reg, zz_reg, ww_reg;
    logic signed [PROD_W-1:0] xy_reg, xz_reg, xw_reg, yz_reg, yw_reg, zw_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xx_reg <= quat.quat_x * quat.quat_x;
            yy_reg <= quat.quat_y * quat.quat_y;
            zz_reg <= quat.quat_z * quat.quat_z;
            ww_reg <= quat.quat_w * quat.quat_w;
            xy_reg <= quat.quat_x * quat.quat_y;
            xz_reg <= quat.quat_x * quat.quat_z;
            xw_reg <= quat.quat_x * quat.quat_w;
            yz_reg <= quat.quat_y * quat.quat_z;
            yw_reg <= quat.quat_y * quat.quat_w;
            zw_reg <= quat.quat_z * quat.quat_w;
        end
    end

    // stage 2: norm, signed numerators, magnitude and the top quotient bit
    logic signed [SUM_W-1:0] norm_s;
    logic signed [SUM_W-1:0] num [ENTRIES];
    logic signed [SUM_W-1:0] mag_s [ENTRIES];
    norm_t                   n_val;

    always_comb
    begin
        norm_s = SUM_W'(xx_reg) + SUM_W'(yy_reg) + SUM_W'(zz_reg) + SUM_W'(ww_reg);
        n_val  = norm_s[NORM_W-1:0];
        num[0] = norm_s - 2 * (SUM_W'(yy_reg) + SUM_W'(zz_reg));
        num[1] = 2 * (SUM_W'(xy_reg) - SUM_W'(zw_reg));
        num[2] = 2 * (SUM_W'(xz_reg) + SUM_W'(yw_reg));
        num[3] = 2 * (SUM_W'(xy_reg) + SUM_W'(zw_reg));
        num[4] = norm_s - 2 * (SUM_W'(xx_reg) + SUM_W'(zz_reg));
        num[5] = 2 * (SUM_W'(yz_reg) - SUM_W'(xw_reg));
        num[6] = 2 * (SUM_W'(xz_reg) - SUM_W'(yw_reg));
        num[7] = 2 * (SUM_W'(yz_reg) + SUM_W'(xw_reg));
        num[8] = norm_s - 2 * (SUM_W'(xx_reg) + SUM_W'(yy_reg));
        for (int i = 0; i < ENTRIES; i++)
        begin
            mag_s[i] = num[i][SUM_W-1] ? -num[i] : num[i];
        end
    end

    norm_t          n_pipe     [DIV_STAGES+1];
    logic           degen_pipe [DIV_STAGES+1];
    logic           neg_pipe   [DIV_STAGES+1][ENTRIES];
    norm_t          rem_pipe   [DIV_STAGES+1][ENTRIES];
    quot_t          quot_pipe  [DIV_STAGES+1][ENTRIES];

    // magnitude never exceeds the norm, so the top bit is set only on equality
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_pipe[0]     <= n_val;
            degen_pipe[0] <= (n_val == '0);
            for (int i = 0; i < ENTRIES; i++)
            begin
                neg_pipe[0][i] <= num[i][SUM_W-1];
                if (mag_s[i][NORM_W-1:0] >= n_val)
                begin
                    rem_pipe[0][i]  <= mag_s[i][NORM_W-1:0] - n_val;
                    quot_pipe[0][i] <= quot_t'(1);
                end
                else
                begin
                    rem_pipe[0][i]  <= mag_s[i][NORM_W-1:0];
                    quot_pipe[0][i] <= '0;
                end
            end
        end
    end

    // divider stages
    for (genvar s = 0; s < DIV_STAGES; s++)
    begin : g_div
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                n_pipe[s+1]     <= n_pipe[s];
                degen_pipe[s+1] <= degen_pipe[s];
                neg_pipe[s+1]   <= neg_pipe[s];
            end
        end
        for (genvar i = 0; i < ENTRIES; i++)
        begin : g_lane
            q2r_div_step u_step (
                .clk      (clk),
                .en       (en),
                .n        (n_pipe[s]),
                .rem_in   (rem_pipe[s][i]),
                .quot_in  (quot_pipe[s][i]),
                .rem_reg  (rem_pipe[s+1][i]),
                .quot_reg (quot_pipe[s+1][i])
            );
        end
    end

    // last stage: round half up on the extra quotient bit, clamp, apply sign
    entry_t          m_reg [ENTRIES];
    logic            degen_reg;
    logic [QUOT_W:0] rnd [ENTRIES];
    entry_t          mag_r [ENTRIES];

    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            rnd[i]   = ({1'b0, quot_pipe[DIV_STAGES][i]} + 1'b1) >> 1;
            mag_r[i] = (rnd[i] > (QUOT_W+1)'(ONE_Q14)) ? ONE_Q14 : entry_t'(rnd[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            degen_reg <= degen_pipe[DIV_STAGES];
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (degen_pipe[DIV_STAGES])
                begin
                    m_reg[i] <= (i % 4 == 0) ? ONE_Q14 : '0;
                end
                else
                begin
                    m_reg[i] <= neg_pipe[DIV_STAGES][i] ? -mag_r[i] : mag_r[i];
                end
            end
        end
    end

    assign matrix.valid      = valid_reg[LAT-1];
    assign matrix.m00        = m_reg[0];
    assign matrix.m01        = m_reg[1];
    assign matrix.m02        = m_reg[2];
    assign matrix.m10        = m_reg[3];
    assign matrix.m11        = m_reg[4];
    assign matrix.m12        = m_reg[5];
    assign matrix.m20        = m_reg[6];
    assign matrix.m21        = m_reg[7];
    assign matrix.m22        = m_reg[8];
    assign matrix.degenerate = degen_reg;

`ifndef SYNTHESIS
    a_accept_enters : assert property (@(posedge clk) disable iff (!rst_n)
        quat.valid && quat.ready |=> valid_reg[0])
        else $error("accepted transaction did not enter the pipeline");

    a_stall_holds : assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(valid_reg))
        else $error("pipeline moved during a stall");

    a_identity : assert property (@(posedge clk) disable iff (!rst_n)
        matrix.valid && matrix.degenerate |->
            matrix.m00 == ONE_Q14 && matrix.m11 == ONE_Q14 &&
            matrix.m22 == ONE_Q14 && matrix.m01 == '0 && matrix.m12 == '0)
        else $error("degenerate result is not the identity");

    a_range : assert property (@(posedge clk) disable iff (!rst_n)
        matrix.valid |-> matrix.m01 <= ONE_Q14 && matrix.m01 >= -ONE_Q14 &&
            matrix.m00 <= ONE_Q14 && matrix.m00 >= -ONE_Q14)
        else $error("matrix entry out of range");
`endif
endmodule
`default_nettype wire
